// File: design/arc4kg_pkg.sv
// Shared types and constants for the arc4 keystream generator.
// No dependencies; every other design file imports this package.
package arc4kg_pkg;

  localparam int PermDepth = 256;
  localparam int ByteW     = 8;
  localparam int BudgetW   = 20;
  localparam int DropW     = 16;
  localparam int SizeW     = 4;
  localparam int WordW     = 64;
  localparam int CfgIndexW = 1;
  localparam int CfgDataW  = 20;

  // request codes
  localparam logic [1:0] REQ_IDENT = 2'd0;
  localparam logic [1:0] REQ_MIX   = 2'd1;
  localparam logic [1:0] REQ_STIR  = 2'd2;
  localparam logic [1:0] REQ_GEN   = 2'd3;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] CFG_RESEED = 1'b0;
  localparam logic [CfgIndexW-1:0] CFG_DROP   = 1'b1;

  localparam logic [BudgetW-1:0] ReseedReset = 20'd100000;
  localparam logic [DropW-1:0]   DropReset   = 16'd3072;
  localparam logic [SizeW-1:0]   MaxBytes    = 4'd8;

  typedef struct packed {
    logic [BudgetW-1:0] reseed_interval;
    logic [DropW-1:0]   drop_count;
  } cfg_t;

  typedef struct packed {
    logic             en;
    logic [ByteW-1:0] addr;
    logic [ByteW-1:0] data;
  } mem_wr_t;

endpackage

// File: design/arc4kg_cfg_regs.sv
// Configuration registers: reseed interval and drop count.
// Depends on arc4kg_pkg for widths, indexes and reset values.
module arc4kg_cfg_regs import arc4kg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0]  cfg_data,
  output cfg_t                 cfg
);

  // write the addressed register, hold the other
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reseed_interval <= ReseedReset;
      cfg.drop_count      <= DropReset;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_RESEED: cfg.reseed_interval <= cfg_data[BudgetW-1:0];
        CFG_DROP:   cfg.drop_count      <= cfg_data[DropW-1:0];
        default:    ;
      endcase
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst) !cfg_we |=> $stable(cfg))
    else $error("config changed without a write");
  a_drop: assert property (@(posedge clk) disable iff (rst)
    cfg_we && cfg_addr == CFG_DROP |=> cfg.drop_count == $past(cfg_data[DropW-1:0]))
    else $error("drop count write lost");
  a_reseed: assert property (@(posedge clk) disable iff (rst)
    cfg_we && cfg_addr == CFG_RESEED |=> $stable(cfg.drop_count))
    else $error("reseed write disturbed drop count");

endmodule

// File: design/arc4kg_perm_mem.sv
// Permutation memory: 256 x 8 synchronous RAM, one write and one read port,
// registered read with write-first forwarding; valid bits give identity.
// Depends on arc4kg_pkg.
module arc4kg_perm_mem import arc4kg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             clr,
  input  mem_wr_t          wr,
  input  logic [ByteW-1:0] raddr,
  output logic [ByteW-1:0] rdata
);

  logic [ByteW-1:0]     mem [PermDepth];
  logic [PermDepth-1:0] valid;
  logic [ByteW-1:0]     mem_q;
  logic [ByteW-1:0]     addr_q;
  logic [ByteW-1:0]     fwd_data_q;
  logic                 vld_q;
  logic                 fwd_q;

  // write port and registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    mem_q      <= mem[raddr];
    vld_q      <= valid[raddr];
    addr_q     <= raddr;
    fwd_q      <= wr.en && (wr.addr == raddr);
    fwd_data_q <= wr.data;
  end

  // entries never written since clear read as their own index
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (clr) begin
        valid <= '0;
      end
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
    end
  end

  assign rdata = fwd_q ? fwd_data_q : (vld_q ? mem_q : addr_q);

  a_clr: assert property (@(posedge clk) disable iff (rst) clr && !wr.en |=> valid == '0)
    else $error("clear left valid entries");
  a_fwd: assert property (@(posedge clk) disable iff (rst)
    wr.en && wr.addr == raddr |=> rdata == $past(wr.data))
    else $error("same-entry read missed write data");
  a_wvld: assert property (@(posedge clk) disable iff (rst)
    wr.en |=> valid[$past(wr.addr)])
    else $error("written entry not marked valid");

endmodule

// File: design/arc4_keystream_generator.sv
// Arc4 keystream generator top level: request sequencer around the
// permutation memory. Depends on arc4kg_pkg, arc4kg_cfg_regs, arc4kg_perm_mem.
//
// Usage: a request beat is taken when start is high and busy is low. req_type
// selects identity reset, key byte mix, finish stir or generate word. Each
// request yields one result beat: done is high for one cycle with word and
// reseed_due valid; the receiver cannot stall, so the result must be taken.
// Work per request (a swap step runs through ST_RD_J, ST_SW_I and ST_SW_J,
// bound by the single read port of the permutation memory):
//   identity reset, generate of zero bytes, stir with drop_count zero: none
//   mix key byte: one swap step
//   generate n bytes (n saturates at 8): ST_RD_I, then n swap steps
//   finish stir: ST_RD_I, then drop_count swap steps
// A new request may be accepted in the cycle that done is shown.
// Configuration writes (cfg_we, cfg_addr, cfg_data) take effect at once; the
// user must make them while the block is idle; the block does not enforce
// this. Reset loads the identity permutation through per-entry valid bits,
// so no clearing pass is needed; indices and budget zero, registers default.
module arc4_keystream_generator import arc4kg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           req_type,
  input  logic [ByteW-1:0]     key_byte,
  input  logic [SizeW-1:0]     word_bytes,
  output logic                 done,
  output logic [WordW-1:0]     word,
  output logic                 reseed_due,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0]  cfg_data
);

  typedef enum logic [2:0] {ST_IDLE, ST_RD_I, ST_RD_J, ST_SW_I, ST_SW_J} state_t;
  typedef enum logic [1:0] {MODE_MIX, MODE_DROP, MODE_GEN} mode_t;

  state_t             state;
  mode_t              mode;
  cfg_t               cfg;
  mem_wr_t            wr;
  logic [ByteW-1:0]   raddr;
  logic [ByteW-1:0]   rdata;
  logic [ByteW-1:0]   idx_i;
  logic [ByteW-1:0]   idx_j;
  logic [ByteW-1:0]   val_a;
  logic [ByteW-1:0]   sum_t;
  logic [ByteW-1:0]   key_q;
  logic [ByteW-1:0]   j_sum;
  logic [ByteW-1:0]   ks_byte;
  logic [DropW-1:0]   cnt;
  logic [SizeW-1:0]   n_q;
  logic [SizeW-1:0]   n_sat;
  logic [BudgetW-1:0] budget;
  logic [BudgetW-1:0] budget_next;
  logic [BudgetW-1:0] budget_sub;
  logic [WordW-1:0]   acc;
  logic               accept;
  logic               fin;
  logic               clr;

  arc4kg_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  arc4kg_perm_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .clr   (clr),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign clr    = accept && (req_type == REQ_IDENT);
  assign n_sat  = (word_bytes > MaxBytes) ? MaxBytes : word_bytes;

  // j update: mixing also adds the key byte
  assign j_sum = idx_j + rdata + ((mode == MODE_MIX) ? key_q : '0);

  // output byte: the pending write of entry j is forwarded here
  assign ks_byte = (sum_t == idx_j) ? val_a : rdata;

  assign budget_sub = (budget > {{(BudgetW-SizeW){1'b0}}, n_q})
                    ? budget - {{(BudgetW-SizeW){1'b0}}, n_q} : '0;

  // memory read address and write port
  always_comb begin
    raddr   = idx_i;
    wr.en   = 1'b0;
    wr.addr = idx_i;
    wr.data = rdata;
    unique case (state)
      ST_IDLE: raddr = idx_i;
      ST_RD_I: raddr = idx_i + 8'd1;
      ST_RD_J: raddr = j_sum;
      ST_SW_I: begin
        raddr   = val_a + rdata;
        wr.en   = 1'b1;
        wr.addr = idx_i;
        wr.data = rdata;
      end
      ST_SW_J: begin
        raddr   = idx_i + 8'd1;
        wr.en   = 1'b1;
        wr.addr = idx_j;
        wr.data = val_a;
      end
      default: raddr = idx_i;
    endcase
  end

  // finish detection and budget update
  always_comb begin
    fin         = 1'b0;
    budget_next = budget;
    if (accept) begin
      unique case (req_type)
        REQ_IDENT: begin
          fin         = 1'b1;
          budget_next = '0;
        end
        REQ_MIX: fin = 1'b0;
        REQ_STIR: begin
          if (cfg.drop_count == '0) begin
            fin         = 1'b1;
            budget_next = cfg.reseed_interval;
          end
        end
        REQ_GEN: fin = (n_sat == '0);
        default: fin = 1'b0;
      endcase
    end else if (state == ST_SW_J) begin
      if (mode == MODE_MIX) begin
        fin = 1'b1;
      end else if (cnt == DropW'(1)) begin
        fin         = 1'b1;
        budget_next = (mode == MODE_DROP) ? cfg.reseed_interval : budget_sub;
      end
    end
  end

  // sequencer: state, indices, counters and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      mode   <= MODE_GEN;
      idx_i  <= '0;
      idx_j  <= '0;
      budget <= '0;
      done   <= 1'b0;
      acc    <= '0;
    end else begin
      done   <= fin;
      budget <= budget_next;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            acc   <= '0;
            key_q <= key_byte;
            n_q   <= n_sat;
            unique case (req_type)
              REQ_IDENT: begin
                idx_i <= '0;
                idx_j <= '0;
              end
              REQ_MIX: begin
                mode  <= MODE_MIX;
                state <= ST_RD_J;
              end
              REQ_STIR: begin
                mode  <= MODE_DROP;
                idx_i <= idx_i - 8'd1;
                idx_j <= idx_i - 8'd1;
                cnt   <= cfg.drop_count;
                if (cfg.drop_count != '0) begin
                  state <= ST_RD_I;
                end
              end
              REQ_GEN: begin
                mode <= MODE_GEN;
                cnt  <= {{(DropW-SizeW){1'b0}}, n_sat};
                if (n_sat != '0) begin
                  state <= ST_RD_I;
                end
              end
              default: ;
            endcase
          end
        end
        ST_RD_I: begin
          idx_i <= idx_i + 8'd1;
          state <= ST_RD_J;
        end
        ST_RD_J: begin
          val_a <= rdata;
          idx_j <= j_sum;
          state <= ST_SW_I;
        end
        ST_SW_I: begin
          sum_t <= val_a + rdata;
          state <= ST_SW_J;
        end
        ST_SW_J: begin
          if (mode == MODE_GEN) begin
            acc <= {acc[WordW-ByteW-1:0], ks_byte};
          end
          if (mode == MODE_MIX) begin
            idx_i <= idx_i + 8'd1;
            state <= ST_IDLE;
          end else if (cnt == DropW'(1)) begin
            state <= ST_IDLE;
          end else begin
            // next byte: its read of entry i+1 is already issued
            cnt   <= cnt - DropW'(1);
            idx_i <= idx_i + 8'd1;
            state <= ST_RD_J;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign word       = acc;
  assign reseed_due = (budget == '0);

  a_taken: assert property (@(posedge clk) disable iff (rst) accept |=> busy || done)
    else $error("accepted request neither in work nor finished");
  a_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while still busy");
  a_mix: assert property (@(posedge clk) disable iff (rst)
    state == ST_SW_J && mode == MODE_MIX |=> !busy && done)
    else $error("key mix did not finish after one swap");

endmodule
